// ===== hdl/ptrb_pkg.sv =====
package ptrb_pkg;

	localparam int ENTRY_DEPTH = 256;
	localparam int BYTE_DEPTH  = 4096;
	localparam int ENTRY_AW    = $clog2(ENTRY_DEPTH);
	localparam int BYTE_AW     = $clog2(BYTE_DEPTH);
	localparam int CNT_W       = 9;
	localparam int LEN_W       = 13;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CNT_W-1:0] LIMIT_RESET  = CNT_W'(256);
	localparam logic [LEN_W-1:0] BUDGET_RESET = LEN_W'(4096);

	localparam logic REG_ENTRY_LIMIT = 1'b0;
	localparam logic REG_BYTE_BUDGET = 1'b1;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_IGNORED    = 3'd1,
		ST_DROPPED    = 3'd2,
		ST_BAD_INDEX  = 3'd3,
		ST_UNEXPECTED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_BEGIN   = 2'd0,
		OP_BYTE    = 2'd1,
		OP_READ    = 2'd2,
		OP_UNKNOWN = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		CLS_BEGIN,
		CLS_BYTE,
		CLS_READ,
		CLS_INVALID
	} item_class_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_CLOSE,
		BK_CHECK,
		BK_EVICT_RD,
		BK_EVICT_UPD,
		BK_COMMIT,
		BK_BYTE,
		BK_RD_META,
		BK_RD_CHECK,
		BK_RD_DATA,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		item_class_t  cls;
		logic [15:0]  packet_length;
		logic [1:0]   packet_origin;
		logic         packet_way;
		logic [63:0]  arrival_time;
		logic [7:0]   payload_byte;
		logic [7:0]   entry_index;
		logic [11:0]  byte_offset;
	} item_t;

	typedef struct packed {
		logic [BYTE_AW-1:0] start;
		logic [63:0]        seq;
		logic [1:0]         origin;
		logic               way;
		logic [63:0]        stamp;
	} info_t;

	typedef struct packed {
		logic [CNT_W-1:0] limit;
		logic [LEN_W-1:0] budget;
	} cfg_t;

endpackage

// ===== hdl/ptrb_if.sv =====
interface ptrb_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] packet_length;
	logic [1:0]  packet_origin;
	logic        packet_way;
	logic [63:0] arrival_time;
	logic [7:0]  payload_byte;
	logic [7:0]  entry_index;
	logic [11:0] byte_offset;

	modport source (output valid, output opcode, output packet_length, output packet_origin,
		output packet_way, output arrival_time, output payload_byte, output entry_index,
		output byte_offset, input ready);
	modport sink (input valid, input opcode, input packet_length, input packet_origin,
		input packet_way, input arrival_time, input payload_byte, input entry_index,
		input byte_offset, output ready);
endinterface

interface ptrb_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  read_byte;
	logic [12:0] entry_length;
	logic [63:0] entry_sequence;
	logic [1:0]  entry_origin;
	logic        entry_way;
	logic [63:0] entry_time;
	logic [8:0]  kept_entries;
	logic [12:0] kept_bytes;
	logic [63:0] drop_count;

	modport source (output valid, output status, output read_byte, output entry_length,
		output entry_sequence, output entry_origin, output entry_way, output entry_time,
		output kept_entries, output kept_bytes, output drop_count, input ready);
	modport sink (input valid, input status, input read_byte, input entry_length,
		input entry_sequence, input entry_origin, input entry_way, input entry_time,
		input kept_entries, input kept_bytes, input drop_count, output ready);
endinterface

// ===== hdl/packet_trace_ring_buffer_core.sv =====
// Packet capture ring: begin items open a packet (length, source, direction, timestamp),
// byte items fill it, read items return one byte plus the entry's metadata (entry 0 is
// the oldest) together with the retained-entry, retained-byte and drop counters. Every
// item produces exactly one result transfer. Items enter a two-deep queue in the front
// end and are executed one at a time by the back-end sequencer, which owns the size,
// info and byte memories (one write port and one read port, registered read). A byte
// item stores its byte into the open packet; a read checks the index, then the offset
// against the entry's stored size, and returns data after two dependent memory reads;
// a begin closes the open packet, checks its length and evicts the oldest entry as often
// as needed before it is stored, each eviction reading the oldest size from memory. The
// queue and the output register let the input keep transferring while a result waits,
// until the queue is full. No clearing pass is needed after reset. Program entry_limit at
// byte address 0 and byte_budget at byte address 4 over APB, only while the block is idle.
module packet_trace_ring_buffer_core (
	input  logic        clk,
	input  logic        arst_n,
	ptrb_item_if.sink   item,
	ptrb_result_if.source result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [ptrb_pkg::CNT_W-1:0] limit_q;
	logic [ptrb_pkg::LEN_W-1:0] budget_q;
	ptrb_pkg::cfg_t             cfg;
	ptrb_pkg::item_t            head;
	logic                       head_valid;
	logic                       head_pop;
	logic                       cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	// register write: paddr[2] selects the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= ptrb_pkg::LIMIT_RESET;
			budget_q <= ptrb_pkg::BUDGET_RESET;
		end else if (cfg_write) begin
			if (paddr[2] == ptrb_pkg::REG_ENTRY_LIMIT) begin
				limit_q <= pwdata[ptrb_pkg::CNT_W-1:0];
			end else begin
				budget_q <= pwdata[ptrb_pkg::LEN_W-1:0];
			end
		end
	end

	// readback returns the raw register
	assign prdata = (paddr[2] == ptrb_pkg::REG_ENTRY_LIMIT) ?
		32'(limit_q) : 32'(budget_q);

	// clamp to the usable range: zero acts as one, oversize acts as the store depth
	always_comb begin
		if (limit_q == '0) begin
			cfg.limit = ptrb_pkg::CNT_W'(1);
		end else if (limit_q > ptrb_pkg::CNT_W'(ptrb_pkg::ENTRY_DEPTH)) begin
			cfg.limit = ptrb_pkg::CNT_W'(ptrb_pkg::ENTRY_DEPTH);
		end else begin
			cfg.limit = limit_q;
		end
		if (budget_q == '0) begin
			cfg.budget = ptrb_pkg::LEN_W'(1);
		end else if (budget_q > ptrb_pkg::LEN_W'(ptrb_pkg::BYTE_DEPTH)) begin
			cfg.budget = ptrb_pkg::LEN_W'(ptrb_pkg::BYTE_DEPTH);
		end else begin
			cfg.budget = budget_q;
		end
	end

	// front end: accept and classify, hold up to two items
	ptrb_front u_front (
		.clk(clk), .arst_n(arst_n), .item(item),
		.head(head), .head_valid(head_valid), .head_pop(head_pop));

	// back end: execute one item, evict, store, read, and drive the result register
	ptrb_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.head(head), .head_valid(head_valid), .head_pop(head_pop), .result(result));

endmodule

// ===== hdl/ptrb_ram.sv =====
module ptrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/ptrb_front.sv =====
module ptrb_front (
	input  logic           clk,
	input  logic           arst_n,
	ptrb_item_if.sink      item,
	output ptrb_pkg::item_t head,
	output logic           head_valid,
	input  logic           head_pop
);

	localparam int QAW = $clog2(ptrb_pkg::QUEUE_DEPTH);

	ptrb_pkg::item_t slot_q [ptrb_pkg::QUEUE_DEPTH];
	logic [QAW-1:0]  wr_q;
	logic [QAW-1:0]  rd_q;
	logic [QAW:0]    count_q;
	ptrb_pkg::item_t incoming;
	logic            push;

	// classify the opcode once on entry
	always_comb begin
		incoming.packet_length = item.packet_length;
		incoming.packet_origin = item.packet_origin;
		incoming.packet_way    = item.packet_way;
		incoming.arrival_time  = item.arrival_time;
		incoming.payload_byte  = item.payload_byte;
		incoming.entry_index   = item.entry_index;
		incoming.byte_offset   = item.byte_offset;
		case (item.opcode)
			ptrb_pkg::OP_BEGIN: incoming.cls = ptrb_pkg::CLS_BEGIN;
			ptrb_pkg::OP_BYTE:  incoming.cls = ptrb_pkg::CLS_BYTE;
			ptrb_pkg::OP_READ:  incoming.cls = ptrb_pkg::CLS_READ;
			default:            incoming.cls = ptrb_pkg::CLS_INVALID;
		endcase
	end

	assign item.ready = (count_q != (QAW+1)'(ptrb_pkg::QUEUE_DEPTH));
	assign push       = item.valid && item.ready;
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (head_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, head_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/ptrb_back.sv =====
module ptrb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ptrb_pkg::cfg_t  cfg,
	input  ptrb_pkg::item_t head,
	input  logic            head_valid,
	output logic            head_pop,
	ptrb_result_if.source   result
);

	localparam int EAW = ptrb_pkg::ENTRY_AW;
	localparam int BAW = ptrb_pkg::BYTE_AW;
	localparam int CW  = ptrb_pkg::CNT_W;
	localparam int LW  = ptrb_pkg::LEN_W;

	ptrb_pkg::back_state_t state_q, state_d;
	ptrb_pkg::item_t       cur_q;

	logic [EAW-1:0] oldest_q;
	logic [CW-1:0]  total_q;
	logic [LW-1:0]  btotal_q;
	logic [BAW-1:0] wp_q;
	logic [LW-1:0]  pending_q;
	logic [LW-1:0]  newest_len_q;
	logic [63:0]    seq_q;
	logic [63:0]    drops_q;

	ptrb_pkg::status_t res_status_q;
	logic [7:0]        res_byte_q;
	logic [LW-1:0]     res_len_q;
	ptrb_pkg::info_t   res_info_q;

	logic           size_we;
	logic [EAW-1:0] size_waddr, size_raddr;
	logic [LW-1:0]  size_wdata, size_rd;
	logic           info_we;
	ptrb_pkg::info_t info_wdata, info_rd;
	logic           byte_we;
	logic [BAW-1:0] byte_raddr;
	logic [7:0]     byte_rd;

	logic [EAW-1:0] slot_rd, slot_newest, slot_new;
	logic [LW-1:0]  len13, got, lim;
	logic           len_big, need_evict, read_bad, out_free;

	assign slot_rd     = oldest_q + cur_q.entry_index[EAW-1:0];
	assign slot_newest = oldest_q + EAW'(total_q) - 1'b1;
	assign slot_new    = oldest_q + EAW'(total_q);
	assign len13       = cur_q.packet_length[LW-1:0];
	assign got         = newest_len_q - pending_q;
	assign len_big     = cur_q.packet_length > 16'(cfg.budget);
	assign need_evict  = (total_q != '0) && ((total_q >= cfg.limit) ||
		(({1'b0, btotal_q} + {1'b0, len13}) > {1'b0, cfg.budget}));
	assign lim         = size_rd - ((CW'(cur_q.entry_index) == total_q - 1'b1) ?
		pending_q : '0);
	assign read_bad    = LW'(cur_q.byte_offset) >= lim;
	assign out_free    = !result.valid || result.ready;
	assign byte_raddr  = info_rd.start + cur_q.byte_offset[BAW-1:0];

	assign size_raddr = (state_q == ptrb_pkg::BK_EVICT_RD) ? oldest_q : slot_rd;
	assign size_we    = ((state_q == ptrb_pkg::BK_CLOSE) && (pending_q != '0) &&
		(total_q != '0) && (got != '0)) || (state_q == ptrb_pkg::BK_COMMIT);
	assign size_waddr = (state_q == ptrb_pkg::BK_CLOSE) ? slot_newest : slot_new;
	assign size_wdata = (state_q == ptrb_pkg::BK_CLOSE) ? got : len13;
	assign info_we    = (state_q == ptrb_pkg::BK_COMMIT);
	assign info_wdata = '{start: wp_q, seq: seq_q, origin: cur_q.packet_origin,
		way: cur_q.packet_way, stamp: cur_q.arrival_time};
	assign byte_we    = (state_q == ptrb_pkg::BK_BYTE) && (pending_q != '0);

	ptrb_ram #(.WIDTH(LW), .DEPTH(ptrb_pkg::ENTRY_DEPTH)) u_size_ram (
		.clk(clk), .we(size_we), .waddr(size_waddr), .wdata(size_wdata),
		.raddr(size_raddr), .rdata(size_rd));

	ptrb_ram #(.WIDTH($bits(ptrb_pkg::info_t)), .DEPTH(ptrb_pkg::ENTRY_DEPTH)) u_info_ram (
		.clk(clk), .we(info_we), .waddr(slot_new), .wdata(info_wdata),
		.raddr(slot_rd), .rdata(info_rd));

	ptrb_ram #(.WIDTH(8), .DEPTH(ptrb_pkg::BYTE_DEPTH)) u_byte_ram (
		.clk(clk), .we(byte_we), .waddr(wp_q), .wdata(cur_q.payload_byte),
		.raddr(byte_raddr), .rdata(byte_rd));

	always_comb begin
		state_d  = state_q;
		head_pop = 1'b0;
		case (state_q)
			ptrb_pkg::BK_IDLE: begin
				if (head_valid) begin
					head_pop = 1'b1;
					case (head.cls)
						ptrb_pkg::CLS_BEGIN: state_d = ptrb_pkg::BK_CLOSE;
						ptrb_pkg::CLS_BYTE:  state_d = ptrb_pkg::BK_BYTE;
						ptrb_pkg::CLS_READ:  state_d = ptrb_pkg::BK_RD_META;
						default:             state_d = ptrb_pkg::BK_EMIT;
					endcase
				end
			end
			ptrb_pkg::BK_CLOSE: state_d = ptrb_pkg::BK_CHECK;
			ptrb_pkg::BK_CHECK: begin
				if (cur_q.packet_length == '0 || len_big) begin
					state_d = ptrb_pkg::BK_EMIT;
				end else if (need_evict) begin
					state_d = ptrb_pkg::BK_EVICT_RD;
				end else begin
					state_d = ptrb_pkg::BK_COMMIT;
				end
			end
			ptrb_pkg::BK_EVICT_RD:  state_d = ptrb_pkg::BK_EVICT_UPD;
			ptrb_pkg::BK_EVICT_UPD: state_d = ptrb_pkg::BK_CHECK;
			ptrb_pkg::BK_COMMIT:    state_d = ptrb_pkg::BK_EMIT;
			ptrb_pkg::BK_BYTE:      state_d = ptrb_pkg::BK_EMIT;
			ptrb_pkg::BK_RD_META: begin
				if (CW'(cur_q.entry_index) >= total_q) begin
					state_d = ptrb_pkg::BK_EMIT;
				end else begin
					state_d = ptrb_pkg::BK_RD_CHECK;
				end
			end
			ptrb_pkg::BK_RD_CHECK: begin
				state_d = read_bad ? ptrb_pkg::BK_EMIT : ptrb_pkg::BK_RD_DATA;
			end
			ptrb_pkg::BK_RD_DATA: state_d = ptrb_pkg::BK_EMIT;
			ptrb_pkg::BK_EMIT: begin
				if (out_free) begin
					state_d = ptrb_pkg::BK_IDLE;
				end
			end
			default: state_d = ptrb_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptrb_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// payload of the item in work and of its result
	always_ff @(posedge clk) begin
		case (state_q)
			ptrb_pkg::BK_IDLE: begin
				cur_q        <= head;
				res_byte_q   <= '0;
				res_len_q    <= '0;
				res_info_q   <= '0;
				res_status_q <= (head.cls == ptrb_pkg::CLS_INVALID) ?
					ptrb_pkg::ST_UNEXPECTED : ptrb_pkg::ST_OK;
			end
			ptrb_pkg::BK_CHECK: begin
				if (cur_q.packet_length == '0) begin
					res_status_q <= ptrb_pkg::ST_IGNORED;
				end else if (len_big) begin
					res_status_q <= ptrb_pkg::ST_DROPPED;
				end
			end
			ptrb_pkg::BK_BYTE: begin
				if (pending_q == '0) begin
					res_status_q <= ptrb_pkg::ST_UNEXPECTED;
				end
			end
			ptrb_pkg::BK_RD_META: begin
				if (CW'(cur_q.entry_index) >= total_q) begin
					res_status_q <= ptrb_pkg::ST_BAD_INDEX;
				end
			end
			ptrb_pkg::BK_RD_CHECK: begin
				if (read_bad) begin
					res_status_q <= ptrb_pkg::ST_BAD_INDEX;
				end
			end
			ptrb_pkg::BK_RD_DATA: begin
				res_byte_q <= byte_rd;
				res_len_q  <= size_rd;
				res_info_q <= info_rd;
			end
			default: begin
				res_status_q <= res_status_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q     <= '0;
			total_q      <= '0;
			btotal_q     <= '0;
			wp_q         <= '0;
			pending_q    <= '0;
			newest_len_q <= '0;
			seq_q        <= '0;
			drops_q      <= '0;
		end else begin
			case (state_q)
				ptrb_pkg::BK_CLOSE: begin
					if (pending_q != '0 && total_q != '0) begin
						btotal_q <= btotal_q - pending_q;
						if (got == '0) begin
							total_q <= total_q - 1'b1;
						end
					end
					pending_q <= '0;
				end
				ptrb_pkg::BK_CHECK: begin
					if (cur_q.packet_length != '0 && len_big && drops_q != '1) begin
						drops_q <= drops_q + 1'b1;
					end
				end
				ptrb_pkg::BK_EVICT_UPD: begin
					btotal_q <= btotal_q - size_rd;
					oldest_q <= oldest_q + 1'b1;
					total_q  <= total_q - 1'b1;
					if (drops_q != '1) begin
						drops_q <= drops_q + 1'b1;
					end
				end
				ptrb_pkg::BK_COMMIT: begin
					total_q      <= total_q + 1'b1;
					btotal_q     <= btotal_q + len13;
					pending_q    <= len13;
					newest_len_q <= len13;
					if (seq_q != '1) begin
						seq_q <= seq_q + 1'b1;
					end
				end
				ptrb_pkg::BK_BYTE: begin
					if (pending_q != '0) begin
						wp_q      <= wp_q + 1'b1;
						pending_q <= pending_q - 1'b1;
					end
				end
				default: begin
					wp_q <= wp_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (state_q == ptrb_pkg::BK_EMIT && out_free) begin
			result.valid <= 1'b1;
		end else if (result.ready) begin
			result.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ptrb_pkg::BK_EMIT && out_free) begin
			result.status         <= res_status_q;
			result.read_byte      <= res_byte_q;
			result.entry_length   <= res_len_q;
			result.entry_sequence <= res_info_q.seq;
			result.entry_origin   <= res_info_q.origin;
			result.entry_way      <= res_info_q.way;
			result.entry_time     <= res_info_q.stamp;
			result.kept_entries   <= total_q;
			result.kept_bytes     <= btotal_q;
			result.drop_count     <= drops_q;
		end
	end

endmodule

// ===== hdl/ptrb_checker.sv =====
module ptrb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [2:0]  status,
	input logic [7:0]  read_byte,
	input logic [12:0] entry_length,
	input logic [8:0]  kept_entries,
	input logic [12:0] kept_bytes
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(status) && $stable(kept_bytes))
		else $error("result dropped while stalled");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status != ptrb_pkg::ST_OK |-> read_byte == '0 && entry_length == '0)
		else $error("entry fields set on a result that is not a good read");

	a_empty_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kept_entries == '0 |-> kept_bytes == '0)
		else $error("bytes retained with no entries");

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> kept_bytes <= 13'(ptrb_pkg::BYTE_DEPTH) &&
			kept_entries <= 9'(ptrb_pkg::ENTRY_DEPTH))
		else $error("retained counts beyond the store");

endmodule

bind packet_trace_ring_buffer_core ptrb_checker u_ptrb_checker (
	.clk(clk), .arst_n(arst_n), .valid(result.valid), .ready(result.ready),
	.status(result.status), .read_byte(result.read_byte),
	.entry_length(result.entry_length), .kept_entries(result.kept_entries),
	.kept_bytes(result.kept_bytes));

// ===== tb/ptrb_tb_pkg.sv =====
`timescale 1ns / 100ps
package ptrb_tb_pkg;
	import ptrb_pkg::*;

	typedef struct {
		logic [2:0]  status;
		logic [7:0]  read_byte;
		logic [12:0] entry_length;
		logic [63:0] entry_sequence;
		logic [1:0]  entry_origin;
		logic        entry_way;
		logic [63:0] entry_time;
		logic [8:0]  kept_entries;
		logic [12:0] kept_bytes;
		logic [63:0] drop_count;
	} capture_result_t;

	typedef struct {
		logic [1:0]  opcode;
		logic [15:0] packet_length;
		logic [1:0]  packet_origin;
		logic        packet_way;
		logic [63:0] arrival_time;
		logic [7:0]  payload_byte;
		logic [7:0]  entry_index;
		logic [11:0] byte_offset;
	} capture_item_t;

	class capture_scoreboard;
		logic [7:0]  store_bytes [BYTE_DEPTH];
		logic [11:0] slot_start [ENTRY_DEPTH];
		logic [12:0] slot_size [ENTRY_DEPTH];
		logic [63:0] slot_seq [ENTRY_DEPTH];
		logic [1:0]  slot_origin [ENTRY_DEPTH];
		logic        slot_way [ENTRY_DEPTH];
		logic [63:0] slot_stamp [ENTRY_DEPTH];
		int unsigned head, count, bytes_held, wr_ptr, pending;
		logic [63:0] next_seq, drops;
		int unsigned limit_reg, budget_reg;
		capture_result_t expected_mem [int];
		int unsigned exp_wr, exp_rd;
		int unsigned errors, checked, good_reads;

		function new();
			head = 0; count = 0; bytes_held = 0; wr_ptr = 0; pending = 0;
			next_seq = 0; drops = 0; limit_reg = 256; budget_reg = 4096;
			exp_wr = 0; exp_rd = 0;
			errors = 0; checked = 0; good_reads = 0;
		endfunction

		function int unsigned outstanding();
			return exp_wr - exp_rd;
		endfunction

		function void set_limit(int unsigned v);
			limit_reg = v & 'h1FF;
		endfunction

		function void set_budget(int unsigned v);
			budget_reg = v & 'h1FFF;
		endfunction

		function int unsigned eff_limit();
			if (limit_reg == 0) return 1;
			if (limit_reg > ENTRY_DEPTH) return ENTRY_DEPTH;
			return limit_reg;
		endfunction

		function int unsigned eff_budget();
			if (budget_reg == 0) return 1;
			if (budget_reg > BYTE_DEPTH) return BYTE_DEPTH;
			return budget_reg;
		endfunction

		function void bump_drops();
			if (drops != '1) drops++;
		endfunction

		// close a partly filled packet: trim it, or remove it if empty
		function void close_open_packet();
			int unsigned s, got;
			if (pending == 0 || count == 0) begin
				pending = 0;
				return;
			end
			s = (head + count - 1) % ENTRY_DEPTH;
			got = slot_size[s] - pending;
			bytes_held -= pending;
			pending = 0;
			if (got == 0) count--;
			else slot_size[s] = 13'(got);
		endfunction

		function void note_item(capture_item_t it);
			capture_result_t r;
			int unsigned s, lim;
			r = '{default: '0};
			r.status = ST_OK;
			case (it.opcode)
				OP_BEGIN: begin
					close_open_packet();
					if (it.packet_length == 0) r.status = ST_IGNORED;
					else if (it.packet_length > eff_budget()) begin
						bump_drops();
						r.status = ST_DROPPED;
					end else begin
						while (count > 0 && (count >= eff_limit() ||
							bytes_held + it.packet_length > eff_budget())) begin
							bytes_held -= slot_size[head];
							head = (head + 1) % ENTRY_DEPTH;
							count--;
							bump_drops();
						end
						s = (head + count) % ENTRY_DEPTH;
						slot_start[s] = 12'(wr_ptr);
						slot_size[s] = 13'(it.packet_length);
						slot_seq[s] = next_seq;
						if (next_seq != '1) next_seq++;
						slot_origin[s] = it.packet_origin;
						slot_way[s] = it.packet_way;
						slot_stamp[s] = it.arrival_time;
						count++;
						bytes_held += it.packet_length;
						pending = it.packet_length;
					end
				end
				OP_BYTE: begin
					if (pending == 0) r.status = ST_UNEXPECTED;
					else begin
						store_bytes[wr_ptr] = it.payload_byte;
						wr_ptr = (wr_ptr + 1) % BYTE_DEPTH;
						pending--;
					end
				end
				OP_READ: begin
					if (it.entry_index >= count) r.status = ST_BAD_INDEX;
					else begin
						s = (head + it.entry_index) % ENTRY_DEPTH;
						lim = slot_size[s];
						if (it.entry_index == count - 1) lim -= pending;
						if (it.byte_offset >= lim) r.status = ST_BAD_INDEX;
						else begin
							r.read_byte = store_bytes[(slot_start[s] + it.byte_offset) % BYTE_DEPTH];
							r.entry_length = slot_size[s];
							r.entry_sequence = slot_seq[s];
							r.entry_origin = slot_origin[s];
							r.entry_way = slot_way[s];
							r.entry_time = slot_stamp[s];
						end
					end
				end
				default: r.status = ST_UNEXPECTED;
			endcase
			r.kept_entries = 9'(count);
			r.kept_bytes = 13'(bytes_held);
			r.drop_count = drops;
			expected_mem[exp_wr] = r;
			exp_wr++;
		endfunction

		function void check_result(capture_result_t a);
			capture_result_t e;
			if (outstanding() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
				return;
			end
			e = expected_mem[exp_rd];
			expected_mem.delete(exp_rd);
			exp_rd++;
			checked++;
			if (e.status == ST_OK && e.entry_length != 0) good_reads++;
			if (a.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, a.status); errors++;
			end
			if (a.read_byte !== e.read_byte) begin
				$error("read_byte exp %0h got %0h", e.read_byte, a.read_byte); errors++;
			end
			if (a.entry_length !== e.entry_length) begin
				$error("entry_length exp %0d got %0d", e.entry_length, a.entry_length); errors++;
			end
			if (a.entry_sequence !== e.entry_sequence) begin
				$error("entry_sequence exp %0d got %0d", e.entry_sequence, a.entry_sequence);
				errors++;
			end
			if (a.entry_origin !== e.entry_origin) begin
				$error("entry_origin exp %0d got %0d", e.entry_origin, a.entry_origin); errors++;
			end
			if (a.entry_way !== e.entry_way) begin
				$error("entry_way exp %0d got %0d", e.entry_way, a.entry_way); errors++;
			end
			if (a.entry_time !== e.entry_time) begin
				$error("entry_time exp %0h got %0h", e.entry_time, a.entry_time); errors++;
			end
			if (a.kept_entries !== e.kept_entries) begin
				$error("kept_entries exp %0d got %0d", e.kept_entries, a.kept_entries); errors++;
			end
			if (a.kept_bytes !== e.kept_bytes) begin
				$error("kept_bytes exp %0d got %0d", e.kept_bytes, a.kept_bytes); errors++;
			end
			if (a.drop_count !== e.drop_count) begin
				$error("drop_count exp %0d got %0d", e.drop_count, a.drop_count); errors++;
			end
		endfunction
	endclass
endpackage

// ===== tb/tb_packet_trace_ring_buffer_core.sv =====
`timescale 1ns / 100ps
module tb_packet_trace_ring_buffer_core;
	import ptrb_pkg::*;
	import ptrb_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	ptrb_item_if item_ch ();
	ptrb_result_if result_ch ();

	capture_scoreboard capture_sb = new();
	// idle chance in percent, shared by both sides; zero gives a stretch of full rate
	int unsigned idle_pct = 9;
	int unsigned n_sent = 0, n_begins = 0;

	packet_trace_ring_buffer_core dut (
		.clk(clk), .arst_n(arst_n), .item(item_ch.sink), .result(result_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		item_ch.valid = 1'b0;
		item_ch.opcode = '0;
		item_ch.packet_length = '0;
		item_ch.packet_origin = '0;
		item_ch.packet_way = 1'b0;
		item_ch.arrival_time = '0;
		item_ch.payload_byte = '0;
		item_ch.entry_index = '0;
		item_ch.byte_offset = '0;
		result_ch.ready = 1'b0;
	end

	// result side: stall at random, check each transfer at the rising edge
	always @(negedge clk) begin
		if (arst_n) result_ch.ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		capture_result_t r;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			r.status = result_ch.status;
			r.read_byte = result_ch.read_byte;
			r.entry_length = result_ch.entry_length;
			r.entry_sequence = result_ch.entry_sequence;
			r.entry_origin = result_ch.entry_origin;
			r.entry_way = result_ch.entry_way;
			r.entry_time = result_ch.entry_time;
			r.kept_entries = result_ch.kept_entries;
			r.kept_bytes = result_ch.kept_bytes;
			r.drop_count = result_ch.drop_count;
			capture_sb.check_result(r);
		end
	end

	// present one item, hold it until the transfer, then predict its result;
	// valid stays up for a following item and drops only while idling
	task automatic send_item(capture_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.opcode <= it.opcode;
		item_ch.packet_length <= it.packet_length;
		item_ch.packet_origin <= it.packet_origin;
		item_ch.packet_way <= it.packet_way;
		item_ch.arrival_time <= it.arrival_time;
		item_ch.payload_byte <= it.payload_byte;
		item_ch.entry_index <= it.entry_index;
		item_ch.byte_offset <= it.byte_offset;
		do @(posedge clk); while (!item_ch.ready);
		capture_sb.note_item(it);
		n_sent++;
		if (it.opcode == OP_BEGIN) n_begins++;
		@(negedge clk);
	endtask

	function automatic capture_item_t rand_fields();
		capture_item_t it;
		it.opcode = OP_BYTE;
		it.packet_length = 16'($urandom());
		it.packet_origin = 2'($urandom_range(2));
		it.packet_way = 1'($urandom());
		it.arrival_time = {$urandom(), $urandom()};
		it.payload_byte = 8'($urandom());
		it.entry_index = 8'($urandom());
		it.byte_offset = 12'($urandom());
		return it;
	endfunction

	task automatic send_begin(int unsigned len);
		capture_item_t it;
		it = rand_fields();
		it.opcode = OP_BEGIN;
		it.packet_length = 16'(len);
		send_item(it);
	endtask

	task automatic send_byte();
		capture_item_t it;
		it = rand_fields();
		send_item(it);
	endtask

	task automatic send_read(int unsigned idx, int unsigned off);
		capture_item_t it;
		it = rand_fields();
		it.opcode = OP_READ;
		it.entry_index = 8'(idx);
		it.byte_offset = 12'(off);
		send_item(it);
	endtask

	// read an existing byte where one is held, steering clear of never written locations
	task automatic send_good_read();
		int unsigned idx, s, lim;
		if (capture_sb.count == 0) begin
			send_read($urandom(), $urandom());
			return;
		end
		idx = $urandom_range(capture_sb.count - 1);
		s = (capture_sb.head + idx) % ENTRY_DEPTH;
		lim = capture_sb.slot_size[s];
		if (idx == capture_sb.count - 1) lim -= capture_sb.pending;
		if (lim == 0) send_read(idx, 0);
		else send_read(idx, $urandom_range(lim - 1));
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (capture_sb.outstanding() != 0) @(negedge clk);
		// then idle before touching the registers
		repeat (20) @(negedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic set_limits(int unsigned lim, int unsigned bud);
		wait_drained();
		apb_write(3'(REG_ENTRY_LIMIT) << 2, lim);
		capture_sb.set_limit(lim);
		apb_write(3'(REG_BYTE_BUDGET) << 2, bud);
		capture_sb.set_budget(bud);
	endtask

	// a complete packet (or partial one when cut short), then some reads
	task automatic random_packet(int unsigned max_len, bit cut_short);
		int unsigned len, nb;
		len = $urandom_range(max_len, 1);
		send_begin(len);
		nb = cut_short ? $urandom_range(len) : len;
		repeat (nb) send_byte();
		repeat ($urandom_range(3)) send_good_read();
	endtask

	task automatic random_phase(int unsigned n_items, int unsigned max_len);
		int unsigned goal, r;
		goal = n_sent + n_items;
		while (n_sent < goal) begin
			r = $urandom_range(99);
			if (r < 80) random_packet(max_len, $urandom_range(9) == 0);
			else if (r < 85) send_begin($urandom_range(1) ? 0 : $urandom());
			else if (r < 90) send_read($urandom(), $urandom());
			else if (r < 95) begin
				capture_item_t it;
				it = rand_fields();
				it.opcode = $urandom_range(1) ? OP_UNKNOWN : OP_BYTE;
				send_item(it);
			end else send_good_read();
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: stray byte, unknown opcode, empty read, empty and oversize begins
		send_byte();
		begin
			capture_item_t it;
			it = rand_fields();
			it.opcode = OP_UNKNOWN;
			send_item(it);
		end
		send_read(0, 0);
		send_begin(0);
		send_begin(16'hFFFF);
		send_begin(4097);
		// a complete packet, then partial and empty ones cut by the next begin
		send_begin(3);
		repeat (3) send_byte();
		send_read(0, 2);
		send_read(0, 3);
		send_begin(4);
		send_byte();
		send_read(1, 0);
		send_read(1, 1);
		send_begin(2);
		send_read(1, 0);
		send_read(2, 0);
		send_begin(5);
		send_begin(1);
		send_byte();
		send_read(2, 0);
		send_read(255, 4095);

		// pause until everything is out, then shrink the limits for eviction
		set_limits(2, 10);
		random_phase(120, 8);
		set_limits(0, 0);
		random_phase(60, 3);
		set_limits(511, 8191);
		idle_pct = 0;
		random_phase(150, 40);
		idle_pct = 9;
		random_phase(250, 40);
		set_limits(256, 4096);
		random_phase(40, 64);
		set_limits(3, 4096);
		random_phase(80, 48);
		set_limits(256, 4096);
		random_phase(150, 4);
		set_limits($urandom_range(255, 1), $urandom_range(4095, 1));
		random_phase(200, 64);
		set_limits(8, 64);
		random_phase(150, 16);

		item_ch.valid <= 1'b0;
		while (capture_sb.outstanding() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("covered %0d items, %0d packet begins, %0d results checked, %0d good reads",
			n_sent, n_begins, capture_sb.checked, capture_sb.good_reads);
		$display("register settings swept from minimum to beyond maximum with eviction");
		if (capture_sb.errors == 0 && capture_sb.outstanding() == 0)
			$display("packet_trace_ring_buffer_core test passed");
		else
			$display("packet_trace_ring_buffer_core test failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("packet_trace_ring_buffer_core test failed");
		$finish;
	end
endmodule

// ===== packet_trace_ring_buffer_core.f =====
hdl/ptrb_pkg.sv
hdl/ptrb_if.sv
hdl/ptrb_ram.sv
hdl/ptrb_front.sv
hdl/ptrb_back.sv
hdl/packet_trace_ring_buffer_core.sv
hdl/ptrb_checker.sv
tb/ptrb_tb_pkg.sv
tb/tb_packet_trace_ring_buffer_core.sv
